@@ design/sat_pkg.sv @@
`default_nettype none

package sat_pkg;

   localparam int MAX_VERTICES     = 4;
   localparam int COORD_BITS       = 32;
   localparam int NORMAL_FRAC_BITS = 14;

   localparam int SLOTS  = 2 * MAX_VERTICES;
   localparam int SLOTW  = $clog2(SLOTS);
   localparam int VW     = $clog2(MAX_VERTICES);
   localparam int CNTW   = $clog2(MAX_VERTICES + 1);
   localparam int DW     = COORD_BITS + 1;
   localparam int MXW    = (DW > 32) ? DW : 32;
   localparam int NB     = NORMAL_FRAC_BITS + 2;
   localparam int MULW   = (COORD_BITS > 32) ? COORD_BITS : 32;
   localparam int PRODW  = 2 * MULW;
   localparam int PW     = COORD_BITS + NORMAL_FRAC_BITS + 3;
   localparam int SUMW   = PW + VW + 1;
   localparam int GW     = PW + 1;
   localparam int TW     = SUMW + CNTW + 1;
   localparam int ROOTW  = 64;
   localparam int RKW    = 5;
   localparam int LENW   = 32;
   localparam int QW     = NORMAL_FRAC_BITS + 1;
   localparam int DIVNW  = NORMAL_FRAC_BITS + LENW + 1;
   localparam int DIVCW  = $clog2(NORMAL_FRAC_BITS + 1);
   localparam int DEPTHW = 31;
   localparam int OUTNW  = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_SHIFT,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_SUM,
      ST_ROOT,
      ST_PRJ_X,
      ST_PRJ_Y,
      ST_PRJ_ACC,
      ST_AXIS,
      ST_FLIP
   } seq_state_type;

   typedef enum logic [1:0] {
      NS_IDLE,
      NS_ROOT,
      NS_DIV_X,
      NS_DIV_Y
   } norm_state_type;

   typedef struct packed {
      logic               go;
      logic [ROOTW-1:0]   sumsq;
      logic [30:0]        ax;
      logic [30:0]        ay;
   } norm_req_type;

   typedef struct packed {
      logic               done;
      logic [QW-1:0]      qx;
      logic [QW-1:0]      qy;
   } norm_rsp_type;

   function automatic logic [SLOTW-1:0] slot_of(input logic sel, input logic [VW-1:0] idx);
      return (sel ? SLOTW'(MAX_VERTICES) : SLOTW'(0)) + SLOTW'(idx);
   endfunction

   function automatic logic signed [TW-1:0] mul_small(input logic signed [SUMW-1:0] v,
                                                      input logic [CNTW-1:0] n);
      logic signed [TW-1:0] acc;
      acc = '0;
      for (int j = 0; j < CNTW; j++) begin
         if (n[j]) begin
            acc = acc + (TW'(v) <<< j);
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

@@ design/sat_mul.sv @@
`default_nettype none

module sat_mul (
   input  wire logic                               clock,
   input  wire logic signed [sat_pkg::MULW-1:0]    a,
   input  wire logic signed [sat_pkg::MULW-1:0]    b,
   output      logic signed [sat_pkg::PRODW-1:0]   prod_ff
);

   logic signed [sat_pkg::PRODW-1:0] prod_in;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

@@ design/sat_norm.sv @@
`default_nettype none

module sat_norm (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sat_pkg::norm_req_type  req,
   output      sat_pkg::norm_rsp_type  rsp
);

   sat_pkg::norm_state_type state_ff, state_in;
   logic [sat_pkg::ROOTW-1:0] v_ff, v_in, r_ff, r_in, bit_val, r_try;
   logic [sat_pkg::RKW-1:0]   k_ff, k_in;
   logic [sat_pkg::DIVNW-1:0] num_ff, num_in, d_try, ld_x, ld_y;
   logic [sat_pkg::DIVCW-1:0] i_ff, i_in;
   logic [sat_pkg::QW-1:0]    q_ff, q_in, qx_ff, qx_in;
   logic [sat_pkg::LENW-1:0]  len;

   assign len     = r_ff[sat_pkg::LENW-1:0];
   assign bit_val = sat_pkg::ROOTW'(1) << {k_ff, 1'b0};
   assign r_try   = r_ff + bit_val;
   assign d_try   = sat_pkg::DIVNW'(len) << i_ff;
   assign ld_y    = (sat_pkg::DIVNW'(req.ay) << sat_pkg::NORMAL_FRAC_BITS)
                    + sat_pkg::DIVNW'(len >> 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sat_pkg::NS_IDLE:  if (req.go) state_in = sat_pkg::NS_ROOT;
         sat_pkg::NS_ROOT:  if (k_ff == '0) state_in = sat_pkg::NS_DIV_X;
         sat_pkg::NS_DIV_X: if (i_ff == '0) state_in = sat_pkg::NS_DIV_Y;
         sat_pkg::NS_DIV_Y: if (i_ff == '0) state_in = sat_pkg::NS_IDLE;
         default:           state_in = sat_pkg::NS_IDLE;
      endcase
   end

   always_comb begin
      v_in   = v_ff;
      r_in   = r_ff;
      k_in   = k_ff;
      num_in = num_ff;
      i_in   = i_ff;
      q_in   = q_ff;
      qx_in  = qx_ff;
      ld_x   = '0;
      case (state_ff)
         sat_pkg::NS_IDLE: begin
            v_in = req.sumsq;
            r_in = '0;
            k_in = '1;
         end
         sat_pkg::NS_ROOT: begin
            if (v_ff >= r_try) begin
               v_in = v_ff - r_try;
               r_in = (r_ff >> 1) + bit_val;
            end else begin
               r_in = r_ff >> 1;
            end
            k_in = k_ff - 1'b1;
            ld_x = (sat_pkg::DIVNW'(req.ax) << sat_pkg::NORMAL_FRAC_BITS)
                   + sat_pkg::DIVNW'(r_in[sat_pkg::LENW-1:0] >> 1);
            num_in = ld_x;
            i_in   = sat_pkg::DIVCW'(sat_pkg::NORMAL_FRAC_BITS);
            q_in   = '0;
         end
         sat_pkg::NS_DIV_X, sat_pkg::NS_DIV_Y: begin
            if (num_ff >= d_try) begin
               num_in = num_ff - d_try;
               q_in   = q_ff | (sat_pkg::QW'(1) << i_ff);
            end
            i_in = i_ff - 1'b1;
            if (i_ff == '0 && state_ff == sat_pkg::NS_DIV_X) begin
               qx_in  = q_in;
               num_in = ld_y;
               i_in   = sat_pkg::DIVCW'(sat_pkg::NORMAL_FRAC_BITS);
               q_in   = '0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp.done = (state_ff == sat_pkg::NS_DIV_Y) && (i_ff == '0);
      rsp.qx   = qx_ff;
      rsp.qy   = q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sat_pkg::NS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      k_ff   <= k_in;
      num_ff <= num_in;
      i_ff   <= i_in;
      q_ff   <= q_in;
      qx_ff  <= qx_in;
   end

endmodule

`default_nettype wire

@@ design/sat_polygon_polygon_test.sv @@
// channel  | handshake            | ports
// ---------+----------------------+------------------------------------------------
// request  | start & !busy        | req_poly_select req_vertex_x req_vertex_y
//          |                      | req_last_vertex
// response | rsp_valid (1 cycle)  | rsp_overlap rsp_depth rsp_normal_x rsp_normal_y
//          |                      | rsp_edge_owner rsp_edge_index rsp_deep_vertex_index
//
// A vertex item without last_vertex is stored and starts no test. A test item runs
// every edge normal in turn: read, shift, square and sum, root and divide, then
// project each vertex of both polygons and test the axis; a separating axis ends it.
// The root/divide unit and the single shared multiplier serve every edge in turn.
// Synchronous active-high reset clears the vertex counts and the sequencer.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module sat_polygon_polygon_test (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output      logic                                  busy,
   input  wire logic                                  req_poly_select,
   input  wire logic signed [31:0]                    req_vertex_x,
   input  wire logic signed [31:0]                    req_vertex_y,
   input  wire logic                                  req_last_vertex,
   output      logic                                  rsp_valid,
   output      logic                                  rsp_overlap,
   output      logic [30:0]                           rsp_depth,
   output      logic signed [15:0]                    rsp_normal_x,
   output      logic signed [15:0]                    rsp_normal_y,
   output      logic                                  rsp_edge_owner,
   output      logic [1:0]                            rsp_edge_index,
   output      logic [1:0]                            rsp_deep_vertex_index
);

   localparam int CW = sat_pkg::COORD_BITS;

   sat_pkg::seq_state_type state_ff, state_in;

   logic signed [CW-1:0] vx_ff [sat_pkg::SLOTS];
   logic signed [CW-1:0] vy_ff [sat_pkg::SLOTS];
   logic                          wr_en;
   logic [sat_pkg::SLOTW-1:0]     wr_slot;

   logic [sat_pkg::CNTW-1:0] cnt_ff [2];
   logic [sat_pkg::CNTW-1:0] cnt_in [2];
   logic [sat_pkg::CNTW-1:0] n_ff [2];
   logic [sat_pkg::CNTW-1:0] n_in [2];

   logic                         own_ff, own_in, poly_ff, poly_in, have_ff, have_in;
   logic [sat_pkg::VW-1:0]       edge_ff, edge_in, vi_ff, vi_in;
   logic signed [CW-1:0]         ex_ff, ex_in, ey_ff, ey_in;
   logic [sat_pkg::MXW-1:0]      mx_ff, mx_in, my_ff, my_in;
   logic                         sx_ff, sx_in, sy_ff, sy_in;
   logic signed [sat_pkg::PRODW-1:0] acc_ff, acc_in, prod_ff;
   logic signed [sat_pkg::NB-1:0] nx_ff, nx_in, ny_ff, ny_in;

   logic signed [sat_pkg::PW-1:0]   lo_ff [2], lo_in [2], hi_ff [2], hi_in [2];
   logic signed [sat_pkg::SUMW-1:0] sum_ff [2], sum_in [2];
   logic [sat_pkg::VW-1:0]          amin_ff [2], amin_in [2], amax_ff [2], amax_in [2];

   logic [sat_pkg::GW-1:0]          best_ff, best_in;
   logic signed [sat_pkg::NB-1:0]   bnx_ff, bnx_in, bny_ff, bny_in;
   logic                            bown_ff, bown_in;
   logic [sat_pkg::VW-1:0]          bedge_ff, bedge_in;
   logic signed [sat_pkg::SUMW-1:0] bsum_ff [2], bsum_in [2];
   logic [sat_pkg::VW-1:0]          bmin_ff [2], bmin_in [2], bmax_ff [2], bmax_in [2];

   logic                  rv_ff, rv_in, rov_ff, rov_in, rown_ff, rown_in;
   logic [30:0]           rdep_ff, rdep_in;
   logic signed [15:0]    rnx_ff, rnx_in, rny_ff, rny_in;
   logic [1:0]            redge_ff, redge_in, rdeep_ff, rdeep_in;

   logic [sat_pkg::SLOTW-1:0]       rd_slot;
   logic signed [CW-1:0]            rd_x, rd_y;
   logic signed [sat_pkg::DW-1:0]   dx, dy;
   logic [sat_pkg::MXW-1:0]         mmax;
   logic signed [sat_pkg::MULW-1:0] mul_a, mul_b;
   logic signed [sat_pkg::PW-1:0]   p_val;
   logic signed [sat_pkg::GW-1:0]   gap;
   logic [sat_pkg::GW-1:0]          mag;
   logic                            sep, edge_last, vert_last, b_wrap;
   logic [sat_pkg::CNTW-1:0]        n_own, n_poly;
   logic [sat_pkg::VW-1:0]          b_idx;
   logic signed [sat_pkg::TW-1:0]   t_val;
   logic                            flip;
   logic [sat_pkg::GW-sat_pkg::NORMAL_FRAC_BITS:0] dq;
   logic                            test_go;
   logic [sat_pkg::CNTW-1:0]        n_new [2];

   sat_pkg::norm_req_type nreq;
   sat_pkg::norm_rsp_type nrsp;

   sat_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod_ff)
   );

   sat_norm u_norm (
      .clock (clock),
      .reset (reset),
      .req   (nreq),
      .rsp   (nrsp)
   );

   assign busy = (state_ff != sat_pkg::ST_IDLE);

   // shared combinational terms
   always_comb begin
      n_own     = own_ff ? n_ff[1] : n_ff[0];
      n_poly    = poly_ff ? n_ff[1] : n_ff[0];
      b_wrap    = (sat_pkg::CNTW'(edge_ff) + 1'b1) == n_own;
      b_idx     = b_wrap ? '0 : edge_ff + 1'b1;
      edge_last = b_wrap;
      vert_last = (sat_pkg::CNTW'(vi_ff) + 1'b1) == n_poly;
      case (state_ff)
         sat_pkg::ST_RD_A: rd_slot = sat_pkg::slot_of(own_ff, edge_ff);
         sat_pkg::ST_RD_B: rd_slot = sat_pkg::slot_of(own_ff, b_idx);
         default:          rd_slot = sat_pkg::slot_of(poly_ff, vi_ff);
      endcase
      rd_x = vx_ff[rd_slot];
      rd_y = vy_ff[rd_slot];
      dx   = sat_pkg::DW'(ey_ff) - sat_pkg::DW'(rd_y);
      dy   = sat_pkg::DW'(rd_x) - sat_pkg::DW'(ex_ff);
      mmax = (mx_ff > my_ff) ? mx_ff : my_ff;
      case (state_ff)
         sat_pkg::ST_SQ_X: begin
            mul_a = sat_pkg::MULW'(mx_ff[30:0]);
            mul_b = sat_pkg::MULW'(mx_ff[30:0]);
         end
         sat_pkg::ST_SQ_Y: begin
            mul_a = sat_pkg::MULW'(my_ff[30:0]);
            mul_b = sat_pkg::MULW'(my_ff[30:0]);
         end
         sat_pkg::ST_PRJ_X: begin
            mul_a = sat_pkg::MULW'(rd_x);
            mul_b = sat_pkg::MULW'(nx_ff);
         end
         sat_pkg::ST_PRJ_Y: begin
            mul_a = sat_pkg::MULW'(rd_y);
            mul_b = sat_pkg::MULW'(ny_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      p_val = sat_pkg::PW'(acc_ff + prod_ff);
      gap   = (lo_ff[1] < lo_ff[0]) ? (sat_pkg::GW'(lo_ff[0]) - sat_pkg::GW'(hi_ff[1]))
                                    : (sat_pkg::GW'(lo_ff[1]) - sat_pkg::GW'(hi_ff[0]));
      sep   = gap > 0;
      mag   = sat_pkg::GW'(-gap);
      t_val = sat_pkg::mul_small(bsum_ff[!bown_ff], bown_ff ? n_ff[1] : n_ff[0])
              - sat_pkg::mul_small(bsum_ff[bown_ff], bown_ff ? n_ff[0] : n_ff[1]);
      flip  = t_val <= 0;
      dq    = {1'b0, best_ff[sat_pkg::GW-1:sat_pkg::NORMAL_FRAC_BITS]}
              + (sat_pkg::GW-sat_pkg::NORMAL_FRAC_BITS+1)'(best_ff[sat_pkg::NORMAL_FRAC_BITS-1]);
      for (int s = 0; s < 2; s++) begin
         n_new[s] = cnt_ff[s];
         if (req_poly_select == s[0] && cnt_ff[s] < sat_pkg::CNTW'(sat_pkg::MAX_VERTICES)) begin
            n_new[s] = cnt_ff[s] + 1'b1;
         end
      end
      test_go = start && req_last_vertex && n_new[0] >= sat_pkg::CNTW'(3)
                && n_new[1] >= sat_pkg::CNTW'(3);
      nreq.go    = (state_ff == sat_pkg::ST_SQ_SUM);
      nreq.sumsq = sat_pkg::ROOTW'(acc_ff + prod_ff);
      nreq.ax    = mx_ff[30:0];
      nreq.ay    = my_ff[30:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sat_pkg::ST_IDLE:    if (test_go) state_in = sat_pkg::ST_RD_A;
         sat_pkg::ST_RD_A:    state_in = sat_pkg::ST_RD_B;
         sat_pkg::ST_RD_B:    state_in = (dx == '0 && dy == '0) ? sat_pkg::ST_PRJ_X
                                                                 : sat_pkg::ST_SHIFT;
         sat_pkg::ST_SHIFT:   if (mmax[sat_pkg::MXW-1:31] == '0 && mmax[30])
                                 state_in = sat_pkg::ST_SQ_X;
         sat_pkg::ST_SQ_X:    state_in = sat_pkg::ST_SQ_Y;
         sat_pkg::ST_SQ_Y:    state_in = sat_pkg::ST_SQ_SUM;
         sat_pkg::ST_SQ_SUM:  state_in = sat_pkg::ST_ROOT;
         sat_pkg::ST_ROOT:    if (nrsp.done) state_in = sat_pkg::ST_PRJ_X;
         sat_pkg::ST_PRJ_X:   state_in = sat_pkg::ST_PRJ_Y;
         sat_pkg::ST_PRJ_Y:   state_in = sat_pkg::ST_PRJ_ACC;
         sat_pkg::ST_PRJ_ACC: state_in = (vert_last && !poly_ff) ? sat_pkg::ST_AXIS
                                                                 : sat_pkg::ST_PRJ_X;
         sat_pkg::ST_AXIS: begin
            if (sep) state_in = sat_pkg::ST_IDLE;
            else if (edge_last && !own_ff) state_in = sat_pkg::ST_FLIP;
            else state_in = sat_pkg::ST_RD_A;
         end
         sat_pkg::ST_FLIP:    state_in = sat_pkg::ST_IDLE;
         default:             state_in = sat_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      wr_en = 1'b0;
      wr_slot = sat_pkg::slot_of(req_poly_select, cnt_ff[req_poly_select][sat_pkg::VW-1:0]);
      cnt_in = cnt_ff;
      n_in = n_ff;
      own_in = own_ff; poly_in = poly_ff; have_in = have_ff;
      edge_in = edge_ff; vi_in = vi_ff;
      ex_in = ex_ff; ey_in = ey_ff;
      mx_in = mx_ff; my_in = my_ff; sx_in = sx_ff; sy_in = sy_ff;
      acc_in = acc_ff; nx_in = nx_ff; ny_in = ny_ff;
      lo_in = lo_ff; hi_in = hi_ff; sum_in = sum_ff; amin_in = amin_ff; amax_in = amax_ff;
      best_in = best_ff; bnx_in = bnx_ff; bny_in = bny_ff; bown_in = bown_ff;
      bedge_in = bedge_ff; bsum_in = bsum_ff; bmin_in = bmin_ff; bmax_in = bmax_ff;
      rv_in = 1'b0; rov_in = rov_ff; rown_in = rown_ff; rdep_in = rdep_ff;
      rnx_in = rnx_ff; rny_in = rny_ff; redge_in = redge_ff; rdeep_in = rdeep_ff;
      case (state_ff)
         sat_pkg::ST_IDLE: begin
            if (start) begin
               wr_en = cnt_ff[req_poly_select] < sat_pkg::CNTW'(sat_pkg::MAX_VERTICES);
               cnt_in = n_new;
               if (req_last_vertex) begin
                  cnt_in[0] = '0;
                  cnt_in[1] = '0;
               end
               n_in = n_new;
               own_in = 1'b1;
               edge_in = '0;
               have_in = 1'b0;
            end
         end
         sat_pkg::ST_RD_A: begin
            ex_in = rd_x;
            ey_in = rd_y;
         end
         sat_pkg::ST_RD_B: begin
            sx_in = dx[sat_pkg::DW-1];
            sy_in = dy[sat_pkg::DW-1];
            mx_in = sat_pkg::MXW'(unsigned'(dx[sat_pkg::DW-1] ? -dx : dx));
            my_in = sat_pkg::MXW'(unsigned'(dy[sat_pkg::DW-1] ? -dy : dy));
            nx_in = '0;
            ny_in = '0;
            poly_in = 1'b1;
            vi_in = '0;
         end
         sat_pkg::ST_SHIFT: begin
            if (mmax[sat_pkg::MXW-1:31] != '0) begin
               mx_in = mx_ff >> 1;
               my_in = my_ff >> 1;
            end else if (!mmax[30]) begin
               if (mmax[29:27] == '0) begin
                  mx_in = mx_ff << 4;
                  my_in = my_ff << 4;
               end else begin
                  mx_in = mx_ff << 1;
                  my_in = my_ff << 1;
               end
            end
         end
         sat_pkg::ST_SQ_Y: acc_in = prod_ff;
         sat_pkg::ST_ROOT: begin
            nx_in = sx_ff ? -sat_pkg::NB'(nrsp.qx) : sat_pkg::NB'(nrsp.qx);
            ny_in = sy_ff ? -sat_pkg::NB'(nrsp.qy) : sat_pkg::NB'(nrsp.qy);
         end
         sat_pkg::ST_PRJ_Y: acc_in = prod_ff;
         sat_pkg::ST_PRJ_ACC: begin
            if (vi_ff == '0 || p_val < lo_ff[poly_ff]) begin
               lo_in[poly_ff] = p_val;
               amin_in[poly_ff] = vi_ff;
            end
            if (vi_ff == '0 || p_val > hi_ff[poly_ff]) begin
               hi_in[poly_ff] = p_val;
               amax_in[poly_ff] = vi_ff;
            end
            sum_in[poly_ff] = (vi_ff == '0) ? sat_pkg::SUMW'(p_val)
                                            : sum_ff[poly_ff] + sat_pkg::SUMW'(p_val);
            if (vert_last) begin
               poly_in = 1'b0;
               vi_in = '0;
            end else begin
               vi_in = vi_ff + 1'b1;
            end
         end
         sat_pkg::ST_AXIS: begin
            if (sep) begin
               rv_in = 1'b1; rov_in = 1'b0; rown_in = 1'b0; rdep_in = '0;
               rnx_in = '0; rny_in = '0; redge_in = '0; rdeep_in = '0;
            end else begin
               if (!have_ff || mag < best_ff) begin
                  have_in = 1'b1; best_in = mag; bnx_in = nx_ff; bny_in = ny_ff;
                  bown_in = own_ff; bedge_in = edge_ff; bsum_in = sum_ff;
                  bmin_in = amin_ff; bmax_in = amax_ff;
               end
               if (edge_last) begin
                  own_in = 1'b0;
                  edge_in = '0;
               end else begin
                  edge_in = edge_ff + 1'b1;
               end
            end
         end
         sat_pkg::ST_FLIP: begin
            rv_in = 1'b1;
            rov_in = 1'b1;
            rown_in = bown_ff;
            rdep_in = (dq[sat_pkg::GW-sat_pkg::NORMAL_FRAC_BITS:31] != '0) ? '1 : dq[30:0];
            rnx_in = sat_pkg::OUTNW'(flip ? -bnx_ff : bnx_ff);
            rny_in = sat_pkg::OUTNW'(flip ? -bny_ff : bny_ff);
            redge_in = bedge_ff[1:0];
            rdeep_in = flip ? bmax_ff[!bown_ff][1:0] : bmin_ff[!bown_ff][1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sat_pkg::ST_IDLE;
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
      end
      if (wr_en) begin
         vx_ff[wr_slot] <= req_vertex_x;
         vy_ff[wr_slot] <= req_vertex_y;
      end
      n_ff <= n_in;
      own_ff <= own_in; poly_ff <= poly_in; have_ff <= have_in;
      edge_ff <= edge_in; vi_ff <= vi_in;
      ex_ff <= ex_in; ey_ff <= ey_in;
      mx_ff <= mx_in; my_ff <= my_in; sx_ff <= sx_in; sy_ff <= sy_in;
      acc_ff <= acc_in; nx_ff <= nx_in; ny_ff <= ny_in;
      lo_ff <= lo_in; hi_ff <= hi_in; sum_ff <= sum_in; amin_ff <= amin_in; amax_ff <= amax_in;
      best_ff <= best_in; bnx_ff <= bnx_in; bny_ff <= bny_in; bown_ff <= bown_in;
      bedge_ff <= bedge_in; bsum_ff <= bsum_in; bmin_ff <= bmin_in; bmax_ff <= bmax_in;
      rov_ff <= rov_in; rown_ff <= rown_in; rdep_ff <= rdep_in;
      rnx_ff <= rnx_in; rny_ff <= rny_in; redge_ff <= redge_in; rdeep_ff <= rdeep_in;
   end

   assign rsp_valid             = rv_ff;
   assign rsp_overlap           = rov_ff;
   assign rsp_depth             = rdep_ff;
   assign rsp_normal_x          = rnx_ff;
   assign rsp_normal_y          = rny_ff;
   assign rsp_edge_owner        = rown_ff;
   assign rsp_edge_index        = redge_ff;
   assign rsp_deep_vertex_index = rdeep_ff;

   a_rsp_after_test: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a running test");

   a_sep_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overlap |-> rsp_depth == '0 && rsp_normal_x == '0
         && rsp_normal_y == '0 && !rsp_edge_owner && rsp_edge_index == '0)
      else $error("separated result carries data");

   a_no_test_plain: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last_vertex |=> !busy)
      else $error("plain vertex item started a test");

   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while result shown");

endmodule

`default_nettype wire
